[design/edbm_pkg.sv]
package edbm_pkg;

  localparam int unsigned QUERY_MAX = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned DIST_W    = 6;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QUERY_W   = QUERY_MAX * CHAR_W;
  localparam int unsigned OUT_W     = 48;

  localparam logic [DIST_W-1:0] TAG_MAX      = DIST_W'(QUERY_MAX);
  localparam logic [DIST_W-1:0] DEF_MAX_DIST = DIST_W'(2);
  localparam logic [IDX_W-1:0]  ENTRY_LAST   = '1;

  localparam logic OP_CHAR    = 1'b0;
  localparam logic OP_END     = 1'b1;
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY0,
    CFG_QUERY1,
    CFG_QUERY2,
    CFG_QUERY3,
    CFG_QLEN,
    CFG_MAXD
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // wavefront token passed from one column cell to the next
  typedef struct packed {
    logic              go;
    logic [DIST_W-1:0] cur;   // updated value of the left column
    logic [DIST_W-1:0] prev;  // value of the left column before the update
  } wave_t;

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[design/edbm_cell.sv]
module edbm_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic [edbm_pkg::DIST_W-1:0]   init_i,
  input  logic [edbm_pkg::CHAR_W-1:0]   tag_char_i,
  input  logic [edbm_pkg::CHAR_W-1:0]   query_char_i,
  input  edbm_pkg::wave_t               wave_i,
  output edbm_pkg::wave_t               wave_o,
  output logic [edbm_pkg::DIST_W-1:0]   dp_o
);
  import edbm_pkg::*;

  logic              valid_q, valid_d;
  logic [DIST_W-1:0] dp_q, dp_d;
  logic [DIST_W-1:0] cand_diag, cand_up, cand_left, best;
  wave_t             wave_q, wave_d;

  // an unwritten column reads as its index
  assign dp_o = valid_q ? dp_q : init_i;

  always_comb begin
    cand_diag = wave_i.prev + ((tag_char_i != query_char_i) ? DIST_W'(1) : DIST_W'(0));
    cand_up   = dp_o + DIST_W'(1);
    cand_left = wave_i.cur + DIST_W'(1);
    best      = cand_diag;
    if (cand_up < best) begin
      best = cand_up;
    end
    if (cand_left < best) begin
      best = cand_left;
    end

    valid_d     = valid_q;
    dp_d        = dp_q;
    wave_d.go   = 1'b0;
    wave_d.cur  = best;
    wave_d.prev = dp_o;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (wave_i.go) begin
      valid_d   = 1'b1;
      dp_d      = best;
      wave_d.go = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wave_q  <= '0;
    end else begin
      valid_q <= valid_d;
      wave_q  <= wave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q <= dp_d;
  end

  assign wave_o = wave_q;

endmodule

[design/edbm_ctrl.sv]
module edbm_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             done_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  output logic                             in_ready_o,
  output edbm_pkg::state_e                 state_o
);
  import edbm_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = !out_valid_i || out_ready_i;
      ST_RUN:  in_ready_o = 1'b0;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

[design/edit_distance_best_match.sv]
// Tag character inside the 32-character limit: ready stays low at least until the
// update has rippled through the 32 column cells, one cell per cycle.
// End-of-table and over-length characters bypass the cells. A result is registered at the
// edge that finishes its request and appears on the master side in the next cycle.
// Reset: no request pending, query and length cleared, threshold 2, row at 0..32,
// entry count and best match cleared.
module edit_distance_best_match (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [edbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [edbm_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // tag_char
  input  logic                              s_axis_tuser,   // op
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // entry_index[15:0], distance[21:16], tag_too_long[22], best_found[23],
  // best_index[39:24], best_distance[45:40], zero[47:46]
  output logic [edbm_pkg::OUT_W-1:0]        m_axis_tdata,
  output logic                              m_axis_tuser    // kind
);
  import edbm_pkg::*;

  logic [QUERY_W-1:0] query_q;
  logic [DIST_W-1:0]  qlen_q, maxd_q;

  state_e             state;
  logic               accept, start, done;
  logic               cells_clear;

  logic               start_q, start_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;
  logic [DIST_W-1:0]  tag_len_q, tag_len_d;
  logic               too_long_q, too_long_d;
  logic [IDX_W-1:0]   entry_q, entry_d;
  logic               best_valid_q, best_valid_d;
  logic [DIST_W-1:0]  best_dist_q, best_dist_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic               out_valid_q, out_valid_d;
  logic               out_kind_q, out_kind_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;

  wave_t              wave [QUERY_MAX+1];
  logic [DIST_W-1:0]  dp_all [QUERY_MAX+1];
  logic [DIST_W-1:0]  m_idx, dist_sel;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
      qlen_q  <= '0;
      maxd_q  <= DEF_MAX_DIST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_QUERY0: query_q[0*CFG_W +: CFG_W] <= cfg_data_i;
        CFG_QUERY1: query_q[1*CFG_W +: CFG_W] <= cfg_data_i;
        CFG_QUERY2: query_q[2*CFG_W +: CFG_W] <= cfg_data_i;
        CFG_QUERY3: query_q[3*CFG_W +: CFG_W] <= cfg_data_i;
        CFG_QLEN:   qlen_q <= cfg_data_i[DIST_W-1:0];
        CFG_MAXD:   maxd_q <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign start  = accept && (s_axis_tuser == OP_CHAR) && !too_long_q && (tag_len_q < TAG_MAX);
  assign done   = (state == ST_RUN) && wave[QUERY_MAX].go;

  edbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .done_i      (done),
    .out_valid_i (out_valid_q),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .state_o     (state)
  );

  // column zero always equals the tag length
  assign wave[0] = '{go: start_q, cur: tag_len_q, prev: tag_len_q - DIST_W'(1)};
  assign dp_all[0] = tag_len_q;

  for (genvar j = 1; j <= QUERY_MAX; j++) begin : g_cell
    edbm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .clear_i      (cells_clear),
      .init_i       (DIST_W'(j)),
      .tag_char_i   (char_q),
      .query_char_i (to_lower(query_q[(j-1)*CHAR_W +: CHAR_W])),
      .wave_i       (wave[j-1]),
      .wave_o       (wave[j]),
      .dp_o         (dp_all[j])
    );
  end

  assign m_idx    = (qlen_q > TAG_MAX) ? TAG_MAX : qlen_q;
  assign dist_sel = dp_all[m_idx];

  always_comb begin
    logic              emit, emit_kind, emit_tl, fin_entry, clr_tag, clr_tab;
    logic [DIST_W-1:0] emit_dist;
    logic              found;

    emit      = 1'b0;
    emit_kind = KIND_ENTRY;
    emit_tl   = 1'b0;
    emit_dist = '0;
    fin_entry = 1'b0;
    clr_tag   = 1'b0;
    clr_tab   = 1'b0;
    found     = 1'b0;

    start_d      = start;
    char_d       = char_q;
    last_d       = last_q;
    tag_len_d    = tag_len_q;
    too_long_d   = too_long_q;
    entry_d      = entry_q;
    best_valid_d = best_valid_q;
    best_dist_d  = best_dist_q;
    best_idx_d   = best_idx_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_kind_d   = out_kind_q;
    out_data_d   = out_data_q;

    if (accept) begin
      if (s_axis_tuser == OP_END) begin
        emit      = 1'b1;
        emit_kind = KIND_END;
        clr_tab   = 1'b1;
      end else if (too_long_q || tag_len_q >= TAG_MAX) begin
        too_long_d = 1'b1;
        if (s_axis_tlast) begin
          emit      = 1'b1;
          emit_tl   = 1'b1;
          fin_entry = 1'b1;
        end
      end else begin
        char_d    = to_lower(s_axis_tdata);
        last_d    = s_axis_tlast;
        tag_len_d = tag_len_q + DIST_W'(1);
      end
    end

    if (done && last_q) begin
      emit      = 1'b1;
      emit_dist = dist_sel;
      fin_entry = 1'b1;
      if (!best_valid_q || dist_sel < best_dist_q) begin
        best_valid_d = 1'b1;
        best_dist_d  = dist_sel;
        best_idx_d   = entry_q;
      end
    end

    if (emit) begin
      found       = best_valid_d && (best_dist_d <= maxd_q);
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
      out_data_d  = {2'b00, best_dist_d, best_idx_d, found, emit_tl, emit_dist, entry_q};
    end

    if (fin_entry) begin
      clr_tag = 1'b1;
      if (entry_q != ENTRY_LAST) begin
        entry_d = entry_q + IDX_W'(1);
      end
    end

    if (clr_tag || clr_tab) begin
      tag_len_d  = '0;
      too_long_d = 1'b0;
    end
    if (clr_tab) begin
      entry_d      = '0;
      best_valid_d = 1'b0;
      best_dist_d  = '0;
      best_idx_d   = '0;
    end

    cells_clear = clr_tag || clr_tab;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= 1'b0;
      tag_len_q    <= '0;
      too_long_q   <= 1'b0;
      entry_q      <= '0;
      best_valid_q <= 1'b0;
      best_dist_q  <= '0;
      best_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      start_q      <= start_d;
      tag_len_q    <= tag_len_d;
      too_long_q   <= too_long_d;
      entry_q      <= entry_d;
      best_valid_q <= best_valid_d;
      best_dist_q  <= best_dist_d;
      best_idx_q   <= best_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    last_q     <= last_d;
    out_kind_q <= out_kind_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = out_data_q;

endmodule
